FILE: design/sxd_pkg.sv
// ----------------------------------------------------------------------------
// sxd_pkg
// Shared types and constants for the sprite xor draw frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package sxd_pkg;

    localparam int SPRITE_BITS = 8;
    localparam int PIXEL_BITS  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic       first_row;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

FILE: design/sxd_front.sv
// ----------------------------------------------------------------------------
// sxd_front
// Classifies an incoming beat: target row with vertical wrap and the
// screen-wide sprite mask with horizontal wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module sxd_front
    import sxd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int COL_BITS      = 6,
    parameter int ROW_BITS      = 5
) (
    input  wire logic [1:0]              action,
    input  wire logic [5:0]              x_pos,
    input  wire logic [4:0]              y_pos,
    input  wire logic [3:0]              row_index,
    input  wire logic [7:0]              row_bits,
    input  wire logic                    first_row,
    output cmd_t                         cmd,
    output logic [ROW_BITS-1:0]          row,
    output logic [SCREEN_WIDTH-1:0]      mask
);

    // remainder by three compare-subtract steps, valid for v < 8*m
    function automatic logic [8:0] mod_small(input logic [8:0] v, input logic [8:0] m);
        logic [8:0] r;
        logic [8:0] s;
        r = v;
        for (int k = 2; k >= 0; k--) begin
            s = m << k;
            if (r >= s) begin
                r = r - s;
            end
        end
        return r;
    endfunction

    logic [8:0] row_sum;
    logic [8:0] row_mod;
    logic [8:0] col0;

    always_comb
    begin
        case (action)
            ACT_DRAW: row_sum = 9'(y_pos) + 9'(row_index);
            default:  row_sum = 9'(y_pos);
        endcase
        row_mod = mod_small(row_sum, 9'(SCREEN_HEIGHT));
        row     = row_mod[ROW_BITS-1:0];
    end

    always_comb
    begin
        logic [6:0]          c;
        logic [COL_BITS-1:0] pos;
        col0 = mod_small(9'(x_pos), 9'(SCREEN_WIDTH));
        mask = '0;
        for (int i = 0; i < SPRITE_BITS; i++) begin
            c = col0[6:0] + 7'(i);
            if (c >= 7'(SCREEN_WIDTH)) begin
                c = c - 7'(SCREEN_WIDTH);
            end
            // leftmost column sits at the top bit of the row
            pos = COL_BITS'(SCREEN_WIDTH - 1) - c[COL_BITS-1:0];
            mask[pos] = mask[pos] | row_bits[SPRITE_BITS-1-i];
        end
    end

    assign cmd.action    = action;
    assign cmd.first_row = first_row;

endmodule

`default_nettype wire

FILE: design/sxd_queue.sv
// ----------------------------------------------------------------------------
// sxd_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sxd_queue
    import sxd_pkg::*;
#(
    parameter int DATA_BITS = 72
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] push_data,
    input  wire logic                 pop,
    output logic [DATA_BITS-1:0]      head_data,
    output logic                      not_empty,
    output logic                      full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: design/sxd_back.sv
// ----------------------------------------------------------------------------
// sxd_back
// Frame memory, per-row valid bits and collision flag; reads one row per
// beat, writes it back xored with the mask on draw beats and drives the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sxd_back
    import sxd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int ROW_BITS      = 5
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire cmd_t                    head_cmd,
    input  wire logic [ROW_BITS-1:0]     head_row,
    input  wire logic [SCREEN_WIDTH-1:0] head_mask,
    output logic                         pop,
    output logic                         done,
    output logic                         collision,
    output logic [PIXEL_BITS-1:0]        row_pixels
);

    logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] rd_data_reg;

    back_state_t             state_reg, state_next;
    cmd_t                    cur_cmd_reg;
    logic [ROW_BITS-1:0]     cur_row_reg;
    logic [SCREEN_WIDTH-1:0] cur_mask_reg;

    logic [SCREEN_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                     collision_flag_reg, collision_flag_next;
    logic                     done_reg, done_next;
    logic [PIXEL_BITS-1:0]    row_pixels_reg, row_pixels_next;

    logic                    mem_rd;
    logic                    mem_wr;
    logic [SCREEN_WIDTH-1:0] old_row;
    logic [SCREEN_WIDTH-1:0] wr_data;

    // a row never drawn since the last clear reads as blank
    assign old_row = row_valid_reg[cur_row_reg] ? rd_data_reg : '0;
    assign wr_data = old_row ^ cur_mask_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop                 = 1'b0;
        mem_rd              = 1'b0;
        mem_wr              = 1'b0;
        row_valid_next      = row_valid_reg;
        collision_flag_next = collision_flag_reg;
        done_next           = 1'b0;
        row_pixels_next     = row_pixels_reg;
        case (state_reg)
            BK_IDLE: begin
                pop    = head_valid;
                mem_rd = head_valid;
            end
            BK_EXEC: begin
                done_next       = 1'b1;
                row_pixels_next = '0;
                case (cur_cmd_reg.action)
                    ACT_CLEAR: row_valid_next = '0;
                    ACT_DRAW: begin
                        mem_wr                      = 1'b1;
                        row_valid_next[cur_row_reg] = 1'b1;
                        collision_flag_next = (collision_flag_reg & ~cur_cmd_reg.first_row)
                                              | (|(old_row & cur_mask_reg));
                    end
                    ACT_READ: row_pixels_next = PIXEL_BITS'(old_row);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= BK_IDLE;
            row_valid_reg      <= '0;
            collision_flag_reg <= 1'b0;
            done_reg           <= 1'b0;
        end else begin
            state_reg          <= state_next;
            row_valid_reg      <= row_valid_next;
            collision_flag_reg <= collision_flag_next;
            done_reg           <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_pixels_reg <= row_pixels_next;
        if (pop) begin
            cur_cmd_reg  <= head_cmd;
            cur_row_reg  <= head_row;
            cur_mask_reg <= head_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr) begin
            frame_mem[cur_row_reg] <= wr_data;
        end
        if (mem_rd) begin
            rd_data_reg <= frame_mem[head_row];
        end
    end

    assign done       = done_reg;
    assign collision  = collision_flag_reg;
    assign row_pixels = row_pixels_reg;

endmodule

`default_nettype wire

FILE: design/sprite_xor_draw_collision.sv
// ----------------------------------------------------------------------------
// sprite_xor_draw_collision
// Monochrome frame store with xor sprite-row draw, collision flag, row read
// and single-beat screen clear.
// ----------------------------------------------------------------------------
// Each accepted beat (start high while busy is low) gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall, so results
// come out in order at their own pace. The front part computes the wrapped
// row and sprite mask in the accept cycle and writes a two-entry queue. The
// back part works each beat on the single-port frame memory in state BK_IDLE,
// which issues the registered row read, then BK_EXEC, which does the xor,
// the write on draw beats and the result. It takes no new beat before it is
// through with the last; a beat passes the queue, the row read register and
// the result registers. busy rises while the queue is full. Clear takes
// effect at once through per-row valid bits, so no clearing pass runs after
// reset or on a clear beat. With done, row_pixels is zero except for read
// beats; collision is valid with every done.
`default_nettype none

module sprite_xor_draw_collision
    import sxd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            action,
    input  wire logic [5:0]            x_pos,
    input  wire logic [4:0]            y_pos,
    input  wire logic [3:0]            row_index,
    input  wire logic [7:0]            row_bits,
    input  wire logic                  first_row,
    output logic                       done,
    output logic                       collision,
    output logic [PIXEL_BITS-1:0]      row_pixels
);

    localparam int COL_BITS  = $clog2(SCREEN_WIDTH);
    localparam int ROW_BITS  = $clog2(SCREEN_HEIGHT);
    localparam int CMD_BITS  = $bits(cmd_t);
    localparam int DATA_BITS = CMD_BITS + ROW_BITS + SCREEN_WIDTH;

    cmd_t                    front_cmd;
    logic [ROW_BITS-1:0]     front_row;
    logic [SCREEN_WIDTH-1:0] front_mask;

    logic                    push;
    logic                    pop;
    logic                    q_valid;
    logic                    q_full;
    logic [DATA_BITS-1:0]    q_head;

    cmd_t                    head_cmd;
    logic [ROW_BITS-1:0]     head_row;
    logic [SCREEN_WIDTH-1:0] head_mask;

    sxd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COL_BITS      (COL_BITS),
        .ROW_BITS      (ROW_BITS)
    ) u_front (
        .action    (action),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .row_index (row_index),
        .row_bits  (row_bits),
        .first_row (first_row),
        .cmd       (front_cmd),
        .row       (front_row),
        .mask      (front_mask)
    );

    assign push = start && !busy;
    assign busy = q_full;

    sxd_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_cmd, front_row, front_mask}),
        .pop       (pop),
        .head_data (q_head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign {head_cmd, head_row, head_mask} = q_head;

    sxd_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ROW_BITS      (ROW_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .head_row   (head_row),
        .head_mask  (head_mask),
        .pop        (pop),
        .done       (done),
        .collision  (collision),
        .row_pixels (row_pixels)
    );

    // back part passes through BK_IDLE between beats, so done never repeats back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe on two consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("back part took a beat from an empty queue");

    // a full queue only drains through the back part
    assert property (@(posedge clk) disable iff (!rst_n) busy && !pop |=> busy)
        else $error("queue left full state without a pop");

endmodule

`default_nettype wire
